/* rtl/usb_device_standard_request_handler_defines.svh */
// Assertion macros for the USB standard request handler.
// Included by the checker; needs no other file.
`ifndef USB_DEVICE_STANDARD_REQUEST_HANDLER_DEFINES_SVH
`define USB_DEVICE_STANDARD_REQUEST_HANDLER_DEFINES_SVH

// same-cycle implication
`define UDSRH_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("udsrh: same-cycle check failed");

// next-cycle implication
`define UDSRH_ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("udsrh: next-cycle check failed");

`endif

/* rtl/udsrh_pkg.sv */
// Types, codes and descriptor table for the USB standard request handler.
// No dependencies.
package udsrh_pkg;

  // device states
  localparam logic [2:0] ST_UNATTACHED = 3'd0;
  localparam logic [2:0] ST_POWERED    = 3'd1;
  localparam logic [2:0] ST_DEFAULT    = 3'd2;
  localparam logic [2:0] ST_ADDRESSED  = 3'd3;
  localparam logic [2:0] ST_CONFIGURED = 3'd4;
  localparam logic [2:0] ST_SUSPENDED  = 3'd5;

  // item modes
  localparam logic [2:0] MD_SETUP   = 3'd0;
  localparam logic [2:0] MD_VBUS    = 3'd1;
  localparam logic [2:0] MD_SUSPEND = 3'd2;
  localparam logic [2:0] MD_WAKEUP  = 3'd3;
  localparam logic [2:0] MD_RESET   = 3'd4;

  // reply kinds
  localparam logic [1:0] RP_NONE  = 2'd0;
  localparam logic [1:0] RP_ACK   = 2'd1;
  localparam logic [1:0] RP_DATA  = 2'd2;
  localparam logic [1:0] RP_STALL = 2'd3;

  // request codes
  localparam logic [7:0] RQ_GET_STATUS     = 8'd0;
  localparam logic [7:0] RQ_CLEAR_FEATURE  = 8'd1;
  localparam logic [7:0] RQ_SET_FEATURE    = 8'd3;
  localparam logic [7:0] RQ_SET_ADDRESS    = 8'd5;
  localparam logic [7:0] RQ_GET_DESCRIPTOR = 8'd6;
  localparam logic [7:0] RQ_GET_CONFIG     = 8'd8;
  localparam logic [7:0] RQ_SET_CONFIG     = 8'd9;

  // bmRequestType values
  localparam logic [7:0] RT_OUT_DEVICE = 8'h00;
  localparam logic [7:0] RT_OUT_EP     = 8'h02;
  localparam logic [7:0] RT_IN_DEVICE  = 8'h80;
  localparam logic [7:0] RT_IN_IFACE   = 8'h81;
  localparam logic [7:0] RT_IN_EP      = 8'h82;

  // descriptor types
  localparam logic [7:0] DT_DEVICE = 8'h01;
  localparam logic [7:0] DT_CONFIG = 8'h02;
  localparam logic [7:0] DT_STRING = 8'h03;
  localparam logic [7:0] DT_HID    = 8'h21;
  localparam logic [7:0] DT_REPORT = 8'h22;

  // descriptor ids
  localparam logic [3:0] DS_NONE    = 4'd0;
  localparam logic [3:0] DS_DEVICE  = 4'd1;
  localparam logic [3:0] DS_CONFIG  = 4'd2;
  localparam logic [3:0] DS_LANG    = 4'd3;
  localparam logic [3:0] DS_MAKER   = 4'd4;
  localparam logic [3:0] DS_PRODUCT = 4'd5;
  localparam logic [3:0] DS_SERIAL  = 4'd6;
  localparam logic [3:0] DS_HID     = 4'd7;
  localparam logic [3:0] DS_REPORT  = 4'd8;

  localparam logic [7:0] SERIAL_INDEX  = 8'hDC;
  localparam logic [7:0] FEAT_WAKEUP   = 8'h01;
  localparam logic [6:0] ADDR_MASK     = 7'h7F;
  localparam int         STAT_SELF_BIT = 0;
  localparam int         STAT_WAKE_BIT = 1;

  // configuration port
  localparam int         APB_AW     = 3;
  localparam int         APB_DW     = 32;
  localparam logic [0:0] REG_SELF_PWR = 1'b0;

  typedef struct packed {
    logic [2:0]  mode;
    logic        vbus_present;
    logic [7:0]  request_type;
    logic [7:0]  request_code;
    logic [15:0] request_value;
    logic [15:0] request_index;
    logic [15:0] request_length;
  } item_t;

  typedef struct packed {
    logic [2:0]  device_state;
    logic [1:0]  reply;
    logic [15:0] reply_word;
    logic [3:0]  descriptor_id;
    logic [15:0] transfer_length;
    logic [6:0]  device_address;
  } result_t;

  typedef struct packed {
    logic [3:0]  id;
    logic [15:0] size;
  } desc_t;

  function automatic desc_t desc_lookup(logic [7:0] dtype, logic [7:0] idx);
    desc_t d;
    d.id   = DS_NONE;
    d.size = 16'd0;
    case (dtype)
      DT_DEVICE: begin d.id = DS_DEVICE; d.size = 16'd18; end
      DT_CONFIG: begin d.id = DS_CONFIG; d.size = 16'd41; end
      DT_STRING: begin
        if (idx == SERIAL_INDEX) begin
          d.id = DS_SERIAL; d.size = 16'd42;
        end else if (idx == 8'd0) begin
          d.id = DS_LANG; d.size = 16'd4;
        end else if (idx == 8'd1) begin
          d.id = DS_MAKER; d.size = 16'd24;
        end else if (idx == 8'd2) begin
          d.id = DS_PRODUCT; d.size = 16'd46;
        end
      end
      DT_HID:    begin d.id = DS_HID; d.size = 16'd9; end
      DT_REPORT: begin d.id = DS_REPORT; d.size = 16'd63; end
      default: begin end
    endcase
    return d;
  endfunction

endpackage

/* rtl/udsrh_req_if.sv */
// Request channel: one bus event or setup packet per item.
// Depends on nothing.
interface udsrh_req_if;
  logic        valid;
  logic        ready;
  logic [2:0]  mode;
  logic        vbus_present;
  logic [7:0]  request_type;
  logic [7:0]  request_code;
  logic [15:0] request_value;
  logic [15:0] request_index;
  logic [15:0] request_length;

  modport source (output valid, mode, vbus_present, request_type, request_code,
                  request_value, request_index, request_length, input ready);
  modport sink (input valid, mode, vbus_present, request_type, request_code,
                request_value, request_index, request_length, output ready);
endinterface

/* rtl/udsrh_rsp_if.sv */
// Result channel: one answer item per request item.
// Depends on nothing.
interface udsrh_rsp_if;
  logic        valid;
  logic        ready;
  logic [2:0]  device_state;
  logic [1:0]  reply;
  logic [15:0] reply_word;
  logic [3:0]  descriptor_id;
  logic [15:0] transfer_length;
  logic [6:0]  device_address;

  modport source (output valid, device_state, reply, reply_word, descriptor_id,
                  transfer_length, device_address, input ready);
  modport sink (input valid, device_state, reply, reply_word, descriptor_id,
                transfer_length, device_address, output ready);
endinterface

/* rtl/udsrh_apb.sv */
// APB-style register port holding the self_powered bit.
// Uses udsrh_pkg for address and data widths.
module udsrh_apb (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [udsrh_pkg::APB_AW-1:0]  paddr,
  input  logic [udsrh_pkg::APB_DW-1:0]  pwdata,
  output logic [udsrh_pkg::APB_DW-1:0]  prdata,
  output logic                          pready,
  output logic                          self_powered
);
  logic hit;

  assign pready = 1'b1;
  assign hit    = paddr[2] == udsrh_pkg::REG_SELF_PWR;

  always_ff @(posedge clk) begin
    if (rst) begin
      self_powered <= 1'b0;
    end else if (psel && penable && pwrite && hit) begin
      self_powered <= pwdata[0];
    end
  end

  assign prdata = hit ? {{(udsrh_pkg::APB_DW-1){1'b0}}, self_powered}
                      : {udsrh_pkg::APB_DW{1'b0}};
endmodule

/* rtl/udsrh_engine.sv */
// Device state and request decode: answers the held item, updates state on fire.
// Uses udsrh_pkg for codes, item and result types and the descriptor table.
module udsrh_engine #(
  parameter int ENDPOINTS = 7
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               fire,
  input  logic               self_powered,
  input  udsrh_pkg::item_t   item,
  output udsrh_pkg::result_t result
);
  localparam int EP_W = (ENDPOINTS > 1) ? $clog2(ENDPOINTS) : 1;
  localparam logic [4:0] EP_LIMIT = 5'(ENDPOINTS);
  localparam logic [ENDPOINTS-1:0] EP0_MASK = ENDPOINTS'(1);
  localparam logic [ENDPOINTS-1:0] CFG_MASK = ENDPOINTS'(7);

  logic [2:0]           dev_state, dev_state_next;
  logic                 config_selected, config_selected_next;
  logic [6:0]           addr_reg, addr_reg_next;
  logic                 addr_valid, addr_valid_next;
  logic                 wakeup_enabled, wakeup_enabled_next;
  logic [ENDPOINTS-1:0] halt_flags, halt_flags_next;
  logic [ENDPOINTS-1:0] ep_enabled, ep_enabled_next;

  logic [3:0]      ep;
  logic [EP_W-1:0] ep_idx;
  logic            ep_ok;
  logic            halt_bit;
  logic            en_bit;
  logic [7:0]      lo;
  logic            is_set;
  udsrh_pkg::desc_t dsc;

  assign ep       = item.request_index[3:0];
  assign ep_idx   = ep[EP_W-1:0];
  assign ep_ok    = {1'b0, ep} < EP_LIMIT;
  assign halt_bit = ep_ok ? halt_flags[ep_idx] : 1'b0;
  assign en_bit   = ep_ok ? ep_enabled[ep_idx] : 1'b0;
  assign lo       = item.request_value[7:0];
  assign is_set   = item.request_code == udsrh_pkg::RQ_SET_FEATURE;
  assign dsc      = udsrh_pkg::desc_lookup(item.request_value[15:8], lo);

  always_comb begin
    dev_state_next       = dev_state;
    config_selected_next = config_selected;
    addr_reg_next        = addr_reg;
    addr_valid_next      = addr_valid;
    wakeup_enabled_next  = wakeup_enabled;
    halt_flags_next      = halt_flags;
    ep_enabled_next      = ep_enabled;
    result.reply           = udsrh_pkg::RP_NONE;
    result.reply_word      = 16'd0;
    result.descriptor_id   = udsrh_pkg::DS_NONE;
    result.transfer_length = 16'd0;

    case (item.mode)
      udsrh_pkg::MD_VBUS: begin
        dev_state_next = item.vbus_present ? udsrh_pkg::ST_POWERED
                                           : udsrh_pkg::ST_UNATTACHED;
      end
      udsrh_pkg::MD_SUSPEND: begin
        dev_state_next = udsrh_pkg::ST_SUSPENDED;
      end
      udsrh_pkg::MD_WAKEUP: begin
        if (dev_state == udsrh_pkg::ST_SUSPENDED) begin
          dev_state_next = config_selected ? udsrh_pkg::ST_CONFIGURED :
                           addr_valid ? udsrh_pkg::ST_ADDRESSED : udsrh_pkg::ST_POWERED;
        end
      end
      udsrh_pkg::MD_RESET: begin
        dev_state_next       = udsrh_pkg::ST_DEFAULT;
        config_selected_next = 1'b0;
        addr_reg_next        = 7'd0;
        addr_valid_next      = 1'b0;
        halt_flags_next      = '0;
        ep_enabled_next      = EP0_MASK;
      end
      udsrh_pkg::MD_SETUP: begin
        if (dev_state != udsrh_pkg::ST_UNATTACHED &&
            dev_state != udsrh_pkg::ST_SUSPENDED) begin
          result.reply = udsrh_pkg::RP_STALL;
          case (item.request_code)
            udsrh_pkg::RQ_GET_STATUS: begin
              if (item.request_type == udsrh_pkg::RT_IN_DEVICE) begin
                result.reply_word[udsrh_pkg::STAT_SELF_BIT] = self_powered;
                result.reply_word[udsrh_pkg::STAT_WAKE_BIT] = wakeup_enabled;
                result.reply = udsrh_pkg::RP_DATA;
              end else if (item.request_type == udsrh_pkg::RT_IN_EP && ep_ok) begin
                result.reply_word[0] = halt_bit;
                result.reply = udsrh_pkg::RP_DATA;
              end
              if (result.reply == udsrh_pkg::RP_DATA) begin
                result.transfer_length = (item.request_length < 16'd2)
                                         ? item.request_length : 16'd2;
              end
            end
            udsrh_pkg::RQ_CLEAR_FEATURE, udsrh_pkg::RQ_SET_FEATURE: begin
              if (item.request_type == udsrh_pkg::RT_OUT_DEVICE) begin
                if (lo == udsrh_pkg::FEAT_WAKEUP) begin
                  wakeup_enabled_next = is_set;
                  result.reply = udsrh_pkg::RP_ACK;
                end
              end else if (item.request_type == udsrh_pkg::RT_OUT_EP) begin
                if (lo != 8'd0) begin
                  result.reply = udsrh_pkg::RP_ACK;
                end else if (ep != 4'd0 && ep_ok) begin
                  if (en_bit) begin
                    halt_flags_next[ep_idx] = is_set;
                  end
                  result.reply = udsrh_pkg::RP_ACK;
                end
              end
            end
            udsrh_pkg::RQ_SET_ADDRESS: begin
              if (item.request_type == udsrh_pkg::RT_OUT_DEVICE) begin
                addr_reg_next   = item.request_value[6:0] & udsrh_pkg::ADDR_MASK;
                addr_valid_next = 1'b1;
                dev_state_next  = (addr_reg_next != 7'd0) ? udsrh_pkg::ST_ADDRESSED
                                                          : udsrh_pkg::ST_DEFAULT;
                result.reply = udsrh_pkg::RP_ACK;
              end
            end
            udsrh_pkg::RQ_GET_DESCRIPTOR: begin
              if ((item.request_type == udsrh_pkg::RT_IN_DEVICE ||
                   item.request_type == udsrh_pkg::RT_IN_IFACE) &&
                  dsc.id != udsrh_pkg::DS_NONE) begin
                result.descriptor_id   = dsc.id;
                result.reply           = udsrh_pkg::RP_DATA;
                result.transfer_length = (item.request_length < dsc.size)
                                         ? item.request_length : dsc.size;
              end
            end
            udsrh_pkg::RQ_GET_CONFIG: begin
              if (item.request_type == udsrh_pkg::RT_IN_DEVICE) begin
                result.reply_word[0]   = config_selected;
                result.reply           = udsrh_pkg::RP_DATA;
                result.transfer_length = (item.request_length < 16'd1)
                                         ? item.request_length : 16'd1;
              end
            end
            udsrh_pkg::RQ_SET_CONFIG: begin
              if (item.request_type == udsrh_pkg::RT_OUT_DEVICE && lo <= 8'd1) begin
                config_selected_next = lo[0];
                halt_flags_next      = '0;
                if (lo[0]) begin
                  dev_state_next  = udsrh_pkg::ST_CONFIGURED;
                  ep_enabled_next = CFG_MASK;
                end else begin
                  dev_state_next  = addr_valid ? udsrh_pkg::ST_ADDRESSED
                                               : udsrh_pkg::ST_POWERED;
                  ep_enabled_next = EP0_MASK;
                end
                result.reply = udsrh_pkg::RP_ACK;
              end
            end
            default: begin end
          endcase
        end
      end
      default: begin end
    endcase

    result.device_state   = dev_state_next;
    result.device_address = addr_reg_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dev_state       <= udsrh_pkg::ST_UNATTACHED;
      config_selected <= 1'b0;
      addr_reg        <= 7'd0;
      addr_valid      <= 1'b0;
      wakeup_enabled  <= 1'b0;
      halt_flags      <= '0;
      ep_enabled      <= EP0_MASK;
    end else if (fire) begin
      dev_state       <= dev_state_next;
      config_selected <= config_selected_next;
      addr_reg        <= addr_reg_next;
      addr_valid      <= addr_valid_next;
      wakeup_enabled  <= wakeup_enabled_next;
      halt_flags      <= halt_flags_next;
      ep_enabled      <= ep_enabled_next;
    end
  end
endmodule

/* rtl/usb_device_standard_request_handler.sv */
// Top level of the USB standard request handler: input register, engine, result register.
// Uses udsrh_pkg, udsrh_req_if, udsrh_rsp_if, udsrh_apb and udsrh_engine.
//
//   channel  dir  handshake        carries
//   req      in   valid / ready    bus event or setup packet fields
//   rsp      out  valid / ready    device state, reply, word, descriptor, length, address
//   apb      in   psel / penable   self_powered register, pready always high
//
// Each item sits in the input register, is decoded and applied to the device state,
// and lands in the result register when that register is empty or being read: one
// item per cycle sustained while rsp.ready stays high. Reset (synchronous, rst
// high) empties both registers and restores the unattached state. A stalled result
// holds; the input register still fills and waits behind it, so two items can be buffered.
module usb_device_standard_request_handler #(
  parameter int ENDPOINTS = 7
) (
  input  logic                          clk,
  input  logic                          rst,
  udsrh_req_if.sink                     req,
  udsrh_rsp_if.source                   rsp,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [udsrh_pkg::APB_AW-1:0]  paddr,
  input  logic [udsrh_pkg::APB_DW-1:0]  pwdata,
  output logic [udsrh_pkg::APB_DW-1:0]  prdata,
  output logic                          pready
);
  logic               in_v;
  udsrh_pkg::item_t   in_q;
  logic               out_v;
  udsrh_pkg::result_t out_q;
  udsrh_pkg::result_t res;
  logic               adv;
  logic               self_powered;

  assign adv       = in_v && (!out_v || rsp.ready);
  assign req.ready = !in_v || adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_v  <= 1'b0;
      out_v <= 1'b0;
    end else begin
      if (req.ready) begin
        in_v <= req.valid;
      end
      if (adv) begin
        out_v <= 1'b1;
      end else if (rsp.ready) begin
        out_v <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.ready && req.valid) begin
      in_q.mode           <= req.mode;
      in_q.vbus_present   <= req.vbus_present;
      in_q.request_type   <= req.request_type;
      in_q.request_code   <= req.request_code;
      in_q.request_value  <= req.request_value;
      in_q.request_index  <= req.request_index;
      in_q.request_length <= req.request_length;
    end
    if (adv) begin
      out_q <= res;
    end
  end

  udsrh_apb u_apb (
    .clk          (clk),
    .rst          (rst),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .self_powered (self_powered)
  );

  udsrh_engine #(.ENDPOINTS(ENDPOINTS)) u_engine (
    .clk          (clk),
    .rst          (rst),
    .fire         (adv),
    .self_powered (self_powered),
    .item         (in_q),
    .result       (res)
  );

  assign rsp.valid           = out_v;
  assign rsp.device_state    = out_q.device_state;
  assign rsp.reply           = out_q.reply;
  assign rsp.reply_word      = out_q.reply_word;
  assign rsp.descriptor_id   = out_q.descriptor_id;
  assign rsp.transfer_length = out_q.transfer_length;
  assign rsp.device_address  = out_q.device_address;
endmodule

/* rtl/udsrh_checker.sv */
// Port-level checks on the result channel of the request handler, with its bind.
// Uses udsrh_pkg reply and descriptor codes and the assertion macros header.
`include "usb_device_standard_request_handler_defines.svh"

module udsrh_checker (
  input logic        clk,
  input logic        rst,
  input logic        rsp_valid,
  input logic        rsp_ready,
  input logic [2:0]  device_state,
  input logic [1:0]  reply,
  input logic [15:0] reply_word,
  input logic [3:0]  descriptor_id,
  input logic [15:0] transfer_length,
  input logic [6:0]  device_address
);
  // a stalled result holds its reply, length, address and device state
  `UDSRH_ASSERT_NXT(a_hold, clk, rst, rsp_valid && !rsp_ready, rsp_valid && $stable(reply) && $stable(transfer_length) && $stable(device_address) && $stable(device_state))

  // only data replies carry a word or a length
  `UDSRH_ASSERT_IMP(a_nodata, clk, rst, rsp_valid && reply != udsrh_pkg::RP_DATA, reply_word == 16'd0 && transfer_length == 16'd0 && descriptor_id == udsrh_pkg::DS_NONE)

  // a descriptor reply carries no status word and at most 63 bytes
  `UDSRH_ASSERT_IMP(a_desc, clk, rst, rsp_valid && descriptor_id != udsrh_pkg::DS_NONE, reply == udsrh_pkg::RP_DATA && reply_word == 16'd0 && transfer_length <= 16'd63)

  // short data replies never exceed two bytes
  `UDSRH_ASSERT_IMP(a_short, clk, rst, rsp_valid && reply == udsrh_pkg::RP_DATA && descriptor_id == udsrh_pkg::DS_NONE, transfer_length <= 16'd2 && reply_word <= 16'd3)
endmodule

bind usb_device_standard_request_handler udsrh_checker u_checker (
  .clk             (clk),
  .rst             (rst),
  .rsp_valid       (rsp.valid),
  .rsp_ready       (rsp.ready),
  .device_state    (rsp.device_state),
  .reply           (rsp.reply),
  .reply_word      (rsp.reply_word),
  .descriptor_id   (rsp.descriptor_id),
  .transfer_length (rsp.transfer_length),
  .device_address  (rsp.device_address)
);

/* test/udsrh_checker.sv */
`timescale 1ns / 1ps
// Scoreboard for the USB standard request handler: watches both channels and the
// config port, keeps its own device state model and compares every result item.
// Uses udsrh_pkg, udsrh_req_if and udsrh_rsp_if.
module udsrh_scoreboard #(
  parameter int ENDPOINTS = 7
) (
  input  logic                          clk,
  input  logic                          rst,
  udsrh_req_if                          req,
  udsrh_rsp_if                          rsp,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [udsrh_pkg::APB_AW-1:0]  paddr,
  input  logic [udsrh_pkg::APB_DW-1:0]  pwdata,
  input  logic                          pready,
  output int                            fail_count,
  output int                            outstanding
);

  localparam int ADDR_W = udsrh_pkg::APB_AW;
  localparam logic [ADDR_W-1:0] SELF_PWR_ADDR = ADDR_W'(4 * udsrh_pkg::REG_SELF_PWR);

  logic [2:0]         dev_state;
  logic               cfg_selected;
  logic [6:0]         bus_addr;
  logic               addr_set;
  logic               wake_enabled;
  logic               self_powered;
  logic               halted [ENDPOINTS];
  logic               ep_on [ENDPOINTS];
  udsrh_pkg::result_t expected_q [$];

  function automatic void endpoints_idle();
    for (int i = 0; i < ENDPOINTS; i++) begin
      halted[i] = 1'b0;
      ep_on[i]  = (i == 0);
    end
  endfunction

  function automatic logic [15:0] clipped(logic [15:0] size, logic [15:0] limit);
    return (size > limit) ? limit : size;
  endfunction

  function automatic udsrh_pkg::result_t apply_request(udsrh_pkg::item_t it);
    udsrh_pkg::result_t r;
    logic [3:0]  ep;
    logic [7:0]  lo;
    logic [7:0]  rt;
    logic [3:0]  desc;
    logic [15:0] size;
    logic        ep_ok;
    r     = '0;
    ep    = it.request_index[3:0];
    lo    = it.request_value[7:0];
    rt    = it.request_type;
    desc  = udsrh_pkg::DS_NONE;
    size  = '0;
    ep_ok = int'(ep) < ENDPOINTS;
    r.reply = udsrh_pkg::RP_NONE;
    case (it.mode)
      udsrh_pkg::MD_VBUS:
        dev_state = it.vbus_present ? udsrh_pkg::ST_POWERED : udsrh_pkg::ST_UNATTACHED;
      udsrh_pkg::MD_SUSPEND: dev_state = udsrh_pkg::ST_SUSPENDED;
      udsrh_pkg::MD_WAKEUP: begin
        if (dev_state == udsrh_pkg::ST_SUSPENDED)
          dev_state = cfg_selected ? udsrh_pkg::ST_CONFIGURED :
                      (addr_set ? udsrh_pkg::ST_ADDRESSED : udsrh_pkg::ST_POWERED);
      end
      udsrh_pkg::MD_RESET: begin
        dev_state    = udsrh_pkg::ST_DEFAULT;
        cfg_selected = 1'b0;
        bus_addr     = '0;
        addr_set     = 1'b0;
        endpoints_idle();
      end
      udsrh_pkg::MD_SETUP: begin
        if (dev_state != udsrh_pkg::ST_UNATTACHED && dev_state != udsrh_pkg::ST_SUSPENDED) begin
          r.reply = udsrh_pkg::RP_STALL;
          case (it.request_code)
            udsrh_pkg::RQ_GET_STATUS: begin
              if (rt == udsrh_pkg::RT_IN_DEVICE) begin
                r.reply_word[udsrh_pkg::STAT_SELF_BIT] = self_powered;
                r.reply_word[udsrh_pkg::STAT_WAKE_BIT] = wake_enabled;
                r.reply = udsrh_pkg::RP_DATA;
              end else if (rt == udsrh_pkg::RT_IN_EP && ep_ok) begin
                r.reply_word[0] = halted[ep];
                r.reply = udsrh_pkg::RP_DATA;
              end
              if (r.reply == udsrh_pkg::RP_DATA)
                r.transfer_length = clipped(16'd2, it.request_length);
            end
            udsrh_pkg::RQ_CLEAR_FEATURE, udsrh_pkg::RQ_SET_FEATURE: begin
              if (rt == udsrh_pkg::RT_OUT_DEVICE) begin
                if (lo == udsrh_pkg::FEAT_WAKEUP) begin
                  wake_enabled = (it.request_code == udsrh_pkg::RQ_SET_FEATURE);
                  r.reply = udsrh_pkg::RP_ACK;
                end
              end else if (rt == udsrh_pkg::RT_OUT_EP) begin
                if (lo != 8'd0) begin
                  r.reply = udsrh_pkg::RP_ACK;
                end else if (ep != 4'd0 && ep_ok) begin
                  if (ep_on[ep]) halted[ep] = (it.request_code == udsrh_pkg::RQ_SET_FEATURE);
                  r.reply = udsrh_pkg::RP_ACK;
                end
              end
            end
            udsrh_pkg::RQ_SET_ADDRESS: begin
              if (rt == udsrh_pkg::RT_OUT_DEVICE) begin
                bus_addr  = it.request_value[6:0] & udsrh_pkg::ADDR_MASK;
                addr_set  = 1'b1;
                dev_state = (bus_addr != '0) ? udsrh_pkg::ST_ADDRESSED : udsrh_pkg::ST_DEFAULT;
                r.reply   = udsrh_pkg::RP_ACK;
              end
            end
            udsrh_pkg::RQ_GET_DESCRIPTOR: begin
              if (rt == udsrh_pkg::RT_IN_DEVICE || rt == udsrh_pkg::RT_IN_IFACE) begin
                case (it.request_value[15:8])
                  udsrh_pkg::DT_DEVICE: begin desc = udsrh_pkg::DS_DEVICE; size = 16'd18; end
                  udsrh_pkg::DT_CONFIG: begin desc = udsrh_pkg::DS_CONFIG; size = 16'd41; end
                  udsrh_pkg::DT_STRING: begin
                    if (lo == udsrh_pkg::SERIAL_INDEX) begin
                      desc = udsrh_pkg::DS_SERIAL; size = 16'd42;
                    end else if (lo == 8'd0) begin
                      desc = udsrh_pkg::DS_LANG; size = 16'd4;
                    end else if (lo == 8'd1) begin
                      desc = udsrh_pkg::DS_MAKER; size = 16'd24;
                    end else if (lo == 8'd2) begin
                      desc = udsrh_pkg::DS_PRODUCT; size = 16'd46;
                    end
                  end
                  udsrh_pkg::DT_HID: begin desc = udsrh_pkg::DS_HID; size = 16'd9; end
                  udsrh_pkg::DT_REPORT: begin desc = udsrh_pkg::DS_REPORT; size = 16'd63; end
                  default: begin end
                endcase
                if (desc != udsrh_pkg::DS_NONE) begin
                  r.reply           = udsrh_pkg::RP_DATA;
                  r.descriptor_id   = desc;
                  r.transfer_length = clipped(size, it.request_length);
                end
              end
            end
            udsrh_pkg::RQ_GET_CONFIG: begin
              if (rt == udsrh_pkg::RT_IN_DEVICE) begin
                r.reply_word      = {15'd0, cfg_selected};
                r.reply           = udsrh_pkg::RP_DATA;
                r.transfer_length = clipped(16'd1, it.request_length);
              end
            end
            udsrh_pkg::RQ_SET_CONFIG: begin
              if (rt == udsrh_pkg::RT_OUT_DEVICE && lo <= 8'd1) begin
                cfg_selected = lo[0];
                endpoints_idle();
                if (lo[0]) begin
                  dev_state = udsrh_pkg::ST_CONFIGURED;
                  for (int i = 1; i <= 2; i++)
                    if (i < ENDPOINTS) ep_on[i] = 1'b1;
                end else begin
                  dev_state = addr_set ? udsrh_pkg::ST_ADDRESSED : udsrh_pkg::ST_POWERED;
                end
                r.reply = udsrh_pkg::RP_ACK;
              end
            end
            default: begin end
          endcase
        end
      end
      default: begin end
    endcase
    r.device_state   = dev_state;
    r.device_address = bus_addr;
    return r;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("%0t udsrh mismatch: %s", $time, msg);
    fail_count++;
  endtask

  always @(posedge clk) begin
    udsrh_pkg::result_t got;
    udsrh_pkg::result_t exp;
    if (rst) begin
      dev_state    = udsrh_pkg::ST_UNATTACHED;
      cfg_selected = 1'b0;
      bus_addr     = '0;
      addr_set     = 1'b0;
      wake_enabled = 1'b0;
      self_powered = 1'b0;
      endpoints_idle();
      expected_q.delete();
      fail_count   = 0;
    end else begin
      if (psel && penable && pwrite && pready && paddr == SELF_PWR_ADDR)
        self_powered = pwdata[0];
      if (req.valid && req.ready)
        expected_q.push_back(apply_request('{mode: req.mode, vbus_present: req.vbus_present,
                                             request_type: req.request_type,
                                             request_code: req.request_code,
                                             request_value: req.request_value,
                                             request_index: req.request_index,
                                             request_length: req.request_length}));
      if (rsp.valid && rsp.ready) begin
        got = {rsp.device_state, rsp.reply, rsp.reply_word, rsp.descriptor_id,
               rsp.transfer_length, rsp.device_address};
        if (expected_q.size() == 0) begin
          report_mismatch($sformatf("result item %0h with no request outstanding", got));
        end else begin
          exp = expected_q.pop_front();
          if (got.device_state !== exp.device_state)
            report_mismatch($sformatf("device_state %0d, expected %0d",
                                      got.device_state, exp.device_state));
          if (got.reply !== exp.reply)
            report_mismatch($sformatf("reply %0d, expected %0d", got.reply, exp.reply));
          if (got.reply_word !== exp.reply_word)
            report_mismatch($sformatf("reply_word %0h, expected %0h",
                                      got.reply_word, exp.reply_word));
          if (got.descriptor_id !== exp.descriptor_id)
            report_mismatch($sformatf("descriptor_id %0d, expected %0d",
                                      got.descriptor_id, exp.descriptor_id));
          if (got.transfer_length !== exp.transfer_length)
            report_mismatch($sformatf("transfer_length %0d, expected %0d",
                                      got.transfer_length, exp.transfer_length));
          if (got.device_address !== exp.device_address)
            report_mismatch($sformatf("device_address %0h, expected %0h",
                                      got.device_address, exp.device_address));
        end
      end
    end
    outstanding <= expected_q.size();
  end

endmodule

/* test/usb_device_standard_request_handler_test.sv */
`timescale 1ns / 1ps
// Top of the USB standard request handler testbench: clock, reset, config writes,
// directed and random request items, result back-pressure and the final verdict.
// Uses udsrh_pkg, the two channel interfaces, udsrh_scoreboard and the block itself.
module usb_device_standard_request_handler_test;

  localparam int                ENDPOINTS     = 7;
  localparam int                CYCLE_LIMIT   = 200000;
  localparam logic [2:0]        MD_SPARE_HI   = 3'd7;
  localparam int                ADDR_W        = udsrh_pkg::APB_AW;
  localparam int                DATA_W        = udsrh_pkg::APB_DW;
  localparam logic [ADDR_W-1:0] SELF_PWR_ADDR = ADDR_W'(4 * udsrh_pkg::REG_SELF_PWR);

  logic              clk = 1'b0;
  logic              rst;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata;
  logic [DATA_W-1:0] prdata;
  logic              pready;
  int                fail_count;
  int                outstanding;
  int                cycle_count = 0;
  int                req_idle_pct = 0;
  int                rsp_idle_pct = 0;
  int                items_sent = 0;
  int                setups_sent = 0;

  udsrh_req_if req_ch ();
  udsrh_rsp_if rsp_ch ();

  usb_device_standard_request_handler #(.ENDPOINTS(ENDPOINTS)) dut (
    .clk(clk), .rst(rst), .req(req_ch), .rsp(rsp_ch),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  udsrh_scoreboard #(.ENDPOINTS(ENDPOINTS)) u_scoreboard (
    .clk(clk), .rst(rst), .req(req_ch), .rsp(rsp_ch),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .pready(pready), .fail_count(fail_count), .outstanding(outstanding)
  );

  always #2 clk = ~clk;

  always @(posedge clk) begin
    rsp_ch.ready <= ($urandom_range(99) >= rsp_idle_pct);
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  function automatic udsrh_pkg::item_t event_item(logic [2:0] mode, logic vbus);
    udsrh_pkg::item_t it;
    it.mode           = mode;
    it.vbus_present   = vbus;
    it.request_type   = 8'($urandom);
    it.request_code   = 8'($urandom);
    it.request_value  = 16'($urandom);
    it.request_index  = 16'($urandom);
    it.request_length = 16'($urandom);
    return it;
  endfunction

  function automatic udsrh_pkg::item_t setup_item(logic [7:0] rtype, logic [7:0] code,
                                                  logic [15:0] value, logic [15:0] index,
                                                  logic [15:0] length);
    udsrh_pkg::item_t it;
    it.mode           = udsrh_pkg::MD_SETUP;
    it.vbus_present   = 1'($urandom);
    it.request_type   = rtype;
    it.request_code   = code;
    it.request_value  = value;
    it.request_index  = index;
    it.request_length = length;
    return it;
  endfunction

  // mostly well-formed setups with random content, plus bus events and noise
  function automatic udsrh_pkg::item_t random_item();
    int          roll;
    logic [7:0]  lo;
    logic [7:0]  dtype;
    logic [15:0] value;
    logic [15:0] index;
    logic [15:0] len;
    roll = $urandom_range(99);
    if (roll < 3) return event_item(udsrh_pkg::MD_RESET, 1'($urandom));
    if (roll < 6) return event_item(udsrh_pkg::MD_VBUS, $urandom_range(9) != 0);
    if (roll < 8) return event_item(udsrh_pkg::MD_SUSPEND, 1'($urandom));
    if (roll < 11) return event_item(udsrh_pkg::MD_WAKEUP, 1'($urandom));
    if (roll < 12)
      return event_item(3'($urandom_range(MD_SPARE_HI, udsrh_pkg::MD_RESET + 1)),
                        1'($urandom));
    if (roll < 28) return event_item(udsrh_pkg::MD_SETUP, 1'($urandom));
    len = ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(70));
    index = 16'($urandom);
    if ($urandom_range(3) != 0) index[3:0] = 4'($urandom_range(ENDPOINTS));
    lo = ($urandom_range(3) == 0) ? 8'($urandom) : 8'($urandom_range(2));
    value = {8'($urandom), lo};
    case ($urandom_range(5))
      0: return setup_item($urandom_range(1) ? udsrh_pkg::RT_IN_DEVICE : udsrh_pkg::RT_IN_EP,
                           udsrh_pkg::RQ_GET_STATUS, value, index, len);
      1: return setup_item($urandom_range(1) ? udsrh_pkg::RT_OUT_DEVICE
                                             : udsrh_pkg::RT_OUT_EP,
                           $urandom_range(1) ? udsrh_pkg::RQ_SET_FEATURE
                                             : udsrh_pkg::RQ_CLEAR_FEATURE,
                           value, index, len);
      2: begin
        value = 16'($urandom);
        if ($urandom_range(4) == 0) value[6:0] = '0;
        return setup_item(udsrh_pkg::RT_OUT_DEVICE, udsrh_pkg::RQ_SET_ADDRESS,
                          value, index, len);
      end
      3: begin
        case ($urandom_range(6))
          0: dtype = udsrh_pkg::DT_DEVICE;
          1: dtype = udsrh_pkg::DT_CONFIG;
          2, 3: dtype = udsrh_pkg::DT_STRING;
          4: dtype = udsrh_pkg::DT_HID;
          5: dtype = udsrh_pkg::DT_REPORT;
          default: dtype = 8'($urandom);
        endcase
        if ($urandom_range(4) == 0) lo = udsrh_pkg::SERIAL_INDEX;
        return setup_item($urandom_range(1) ? udsrh_pkg::RT_IN_DEVICE
                                            : udsrh_pkg::RT_IN_IFACE,
                          udsrh_pkg::RQ_GET_DESCRIPTOR, {dtype, lo}, index, len);
      end
      4: return setup_item(udsrh_pkg::RT_IN_DEVICE, udsrh_pkg::RQ_GET_CONFIG,
                           value, index, len);
      default: begin
        if ($urandom_range(4) != 0) value[7:0] = 8'($urandom_range(3) != 0);
        return setup_item(udsrh_pkg::RT_OUT_DEVICE, udsrh_pkg::RQ_SET_CONFIG,
                          value, index, len);
      end
    endcase
  endfunction

  task automatic send_item(input udsrh_pkg::item_t it);
    logic took;
    if ($urandom_range(99) < req_idle_pct) begin
      req_ch.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < req_idle_pct);
    end
    req_ch.valid          <= 1'b1;
    req_ch.mode           <= it.mode;
    req_ch.vbus_present   <= it.vbus_present;
    req_ch.request_type   <= it.request_type;
    req_ch.request_code   <= it.request_code;
    req_ch.request_value  <= it.request_value;
    req_ch.request_index  <= it.request_index;
    req_ch.request_length <= it.request_length;
    do begin
      @(negedge clk);
      took = req_ch.ready;
      @(posedge clk);
    end while (!took);
    items_sent++;
    if (it.mode == udsrh_pkg::MD_SETUP) setups_sent++;
  endtask

  task automatic write_self_powered(input logic value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= SELF_PWR_ADDR;
    pwdata  <= {{(DATA_W-1){1'b0}}, value};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic drain();
    req_ch.valid <= 1'b0;
    do @(negedge clk); while (outstanding != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic run_phase(input int count, input int src_idle, input int snk_idle,
                           input logic self_pwr);
    req_idle_pct  = src_idle;
    rsp_idle_pct <= snk_idle;
    write_self_powered(self_pwr);
    repeat (count) send_item(random_item());
    drain();
  endtask

  initial begin
    rst                   = 1'b1;
    psel                  = 1'b0;
    penable               = 1'b0;
    pwrite                = 1'b0;
    paddr                 = '0;
    pwdata                = '0;
    rsp_ch.ready          = 1'b0;
    req_ch.valid          = 1'b0;
    req_ch.mode           = udsrh_pkg::MD_SETUP;
    req_ch.vbus_present   = 1'b0;
    req_ch.request_type   = '0;
    req_ch.request_code   = '0;
    req_ch.request_value  = '0;
    req_ch.request_index  = '0;
    req_ch.request_length = '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    req_idle_pct  = 16;
    rsp_idle_pct <= 52;
    write_self_powered(1'b1);
    // unattached: setup ignored
    send_item(setup_item(udsrh_pkg::RT_IN_DEVICE, udsrh_pkg::RQ_GET_STATUS, 16'h0000,
                         16'h0000, 16'hFFFF));
    send_item(event_item(udsrh_pkg::MD_VBUS, 1'b1));
    send_item(event_item(udsrh_pkg::MD_RESET, 1'b0));
    send_item(setup_item(udsrh_pkg::RT_IN_DEVICE, udsrh_pkg::RQ_GET_DESCRIPTOR,
                         {udsrh_pkg::DT_DEVICE, 8'h00}, 16'h0000, 16'hFFFF));
    send_item(setup_item(udsrh_pkg::RT_IN_DEVICE, udsrh_pkg::RQ_GET_DESCRIPTOR,
                         {udsrh_pkg::DT_CONFIG, 8'h00}, 16'h0000, 16'd10));
    send_item(setup_item(udsrh_pkg::RT_IN_DEVICE, udsrh_pkg::RQ_GET_DESCRIPTOR,
                         {udsrh_pkg::DT_STRING, udsrh_pkg::SERIAL_INDEX}, 16'h0000, 16'd0));
    send_item(setup_item(udsrh_pkg::RT_IN_DEVICE, udsrh_pkg::RQ_GET_DESCRIPTOR,
                         {udsrh_pkg::DT_STRING, 8'h07}, 16'h0000, 16'd64));
    send_item(setup_item(udsrh_pkg::RT_IN_IFACE, udsrh_pkg::RQ_GET_DESCRIPTOR,
                         {udsrh_pkg::DT_REPORT, 8'h00}, 16'h0000, 16'd63));
    send_item(setup_item(udsrh_pkg::RT_IN_DEVICE, udsrh_pkg::RQ_GET_DESCRIPTOR, 16'hFFFF,
                         16'hFFFF, 16'd64));
    send_item(setup_item(udsrh_pkg::RT_OUT_DEVICE, udsrh_pkg::RQ_SET_ADDRESS, 16'hFFFF,
                         16'h0000, 16'h0000));
    send_item(setup_item(udsrh_pkg::RT_OUT_DEVICE, udsrh_pkg::RQ_SET_FEATURE,
                         {8'h00, udsrh_pkg::FEAT_WAKEUP}, 16'h0000, 16'h0000));
    send_item(setup_item(udsrh_pkg::RT_IN_DEVICE, udsrh_pkg::RQ_GET_STATUS, 16'h0000,
                         16'h0000, 16'd1));
    send_item(setup_item(udsrh_pkg::RT_OUT_DEVICE, udsrh_pkg::RQ_SET_CONFIG, 16'h0001,
                         16'h0000, 16'h0000));
    send_item(setup_item(udsrh_pkg::RT_OUT_EP, udsrh_pkg::RQ_SET_FEATURE, 16'h0000,
                         16'hFFF1, 16'h0000));
    send_item(setup_item(udsrh_pkg::RT_IN_EP, udsrh_pkg::RQ_GET_STATUS, 16'h0000,
                         16'h0001, 16'd2));
    send_item(setup_item(udsrh_pkg::RT_IN_EP, udsrh_pkg::RQ_GET_STATUS, 16'h0000,
                         16'h000F, 16'd2));
    send_item(setup_item(udsrh_pkg::RT_OUT_EP, udsrh_pkg::RQ_CLEAR_FEATURE, 16'h0000,
                         16'h0000, 16'h0000));
    // halt request on a disabled endpoint
    send_item(setup_item(udsrh_pkg::RT_OUT_EP, udsrh_pkg::RQ_SET_FEATURE, 16'h0000,
                         16'h0005, 16'h0000));
    send_item(setup_item(udsrh_pkg::RT_OUT_DEVICE, udsrh_pkg::RQ_SET_CONFIG, 16'h0002,
                         16'h0000, 16'h0000));
    send_item(setup_item(udsrh_pkg::RT_IN_DEVICE, udsrh_pkg::RQ_GET_CONFIG, 16'h0000,
                         16'h0000, 16'hFFFF));
    send_item(setup_item(8'hFF, 8'hFF, 16'hFFFF, 16'hFFFF, 16'hFFFF));
    send_item(event_item(udsrh_pkg::MD_SUSPEND, 1'b0));
    send_item(event_item(udsrh_pkg::MD_WAKEUP, 1'b0));
    send_item(event_item(MD_SPARE_HI, 1'b1));
    send_item(setup_item(udsrh_pkg::RT_OUT_DEVICE, udsrh_pkg::RQ_SET_CONFIG, 16'hFF00,
                         16'h0000, 16'h0000));
    send_item(setup_item(udsrh_pkg::RT_OUT_DEVICE, udsrh_pkg::RQ_SET_ADDRESS, 16'h0080,
                         16'h0000, 16'h0000));
    drain();

    run_phase(520, 16, 52, 1'b0);
    run_phase(520, 52, 16, 1'b1);
    run_phase(510, 0, 0, 1'b0);

    $display("Sent %0d items (%0d setup packets, the rest bus events and stray modes)",
             items_sent, setups_sent);
    $display("under three idle/stall profiles, with self_powered toggled between phases.");
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

/* files.f */
+incdir+rtl
rtl/udsrh_pkg.sv
rtl/udsrh_req_if.sv
rtl/udsrh_rsp_if.sv
rtl/udsrh_apb.sv
rtl/udsrh_engine.sv
rtl/usb_device_standard_request_handler.sv
rtl/udsrh_checker.sv
test/udsrh_checker.sv
test/usb_device_standard_request_handler_test.sv
